// ----- hw/rtl/gbe_pkg.sv -----
// Shared types, widths and codes for the gap buffer edit engine.
`default_nettype none
package gbe_pkg;

  // Store size in bytes
  localparam int CAPACITY = 4096;

  // Fixed port widths
  localparam int POS_W  = 13;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  // Internal widths derived from the store size
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int GAP_W  = $clog2(CAPACITY + 1);
  localparam int EXT_W  = (POS_W > GAP_W) ? POS_W : GAP_W;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [STAT_W-1:0] stat_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [GAP_W-1:0]  gap_t;
  typedef logic [EXT_W-1:0]  ext_t;

  localparam gap_t CAP_G = gap_t'(CAPACITY);

  // Operation codes
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_DELETE = 2'd1;
  localparam kind_t KIND_READ   = 2'd2;

  // Status codes
  localparam stat_t ST_DONE  = 2'd0;
  localparam stat_t ST_FULL  = 2'd1;
  localparam stat_t ST_RANGE = 2'd2;

endpackage
`default_nettype wire

// ----- hw/rtl/gbe_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none
module gbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/gap_buffer_edit_engine_top.sv -----
// Gap buffer edit engine: command sequencer, gap registers and text store.
//
//   channel   handshake            payload
//   command   start / busy         kind, position, data_byte, count
//   result    done (1-cycle pulse) read_byte, length, status
//
// Refused or ignored commands and zero-count deletes give their result
// straight from the idle state; a read does one store read first.
// Insert and delete first shift the gap to the target position, with one
// store read and write-back per byte that the gap moves (none when the gap
// stays put), then apply the edit in the apply state and give their result.
// Reset empties the text (whole store is gap); store contents are not cleared.
// The result is a one-cycle strobe; the receiver cannot stall it.
`default_nettype none
module gap_buffer_edit_engine_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire gbe_pkg::kind_t       kind,
  input  wire gbe_pkg::pos_t        position,
  input  wire gbe_pkg::byte_t       data_byte,
  input  wire gbe_pkg::pos_t        count,
  output logic                      done,
  output gbe_pkg::byte_t            read_byte,
  output gbe_pkg::pos_t             length,
  output gbe_pkg::stat_t            status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_MOVE  = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]      state;
  gbe_pkg::gap_t   gap_first;
  gbe_pkg::gap_t   gap_after;

  // Move sequencer
  logic            dir_right;
  gbe_pkg::gap_t   remain;
  gbe_pkg::addr_t  rd_ptr;
  gbe_pkg::addr_t  wr_ptr;
  logic            pend;
  gbe_pkg::addr_t  pend_addr;

  // Pending insert
  logic            op_insert;
  gbe_pkg::addr_t  ins_addr;
  gbe_pkg::byte_t  ins_byte;

  // Store ports
  logic            ram_we;
  gbe_pkg::addr_t  ram_waddr;
  gbe_pkg::byte_t  ram_wdata;
  gbe_pkg::addr_t  ram_raddr;
  gbe_pkg::byte_t  ram_rdata;

  // Command decode terms
  gbe_pkg::gap_t   len;
  gbe_pkg::ext_t   pos_x;
  gbe_pkg::ext_t   len_x;
  logic            pos_gt;
  logic            pos_ge;
  logic            full;
  gbe_pkg::gap_t   target;
  gbe_pkg::gap_t   avail;
  gbe_pkg::gap_t   del_cnt;
  logic            move_right;
  gbe_pkg::gap_t   move_dist;
  gbe_pkg::gap_t   ga_moved;
  gbe_pkg::gap_t   pos_g;
  gbe_pkg::gap_t   rd_map;
  gbe_pkg::gap_t   rd_start;
  gbe_pkg::gap_t   wr_start;

  assign busy = (state != S_IDLE);

  // Length, clamps and gap move plan for the command on the ports
  always_comb begin
    len        = gbe_pkg::CAP_G - (gap_after - gap_first);
    pos_x      = gbe_pkg::ext_t'(position);
    len_x      = gbe_pkg::ext_t'(len);
    pos_gt     = pos_x > len_x;
    pos_ge     = pos_x >= len_x;
    full       = (len == gbe_pkg::CAP_G);
    pos_g      = gbe_pkg::gap_t'(pos_x);
    target     = pos_gt ? len : pos_g;
    avail      = len - target;
    del_cnt    = (gbe_pkg::ext_t'(count) > gbe_pkg::ext_t'(avail)) ? avail
                 : gbe_pkg::gap_t'(gbe_pkg::ext_t'(count));
    move_right = target > gap_first;
    move_dist  = move_right ? (target - gap_first) : (gap_first - target);
    ga_moved   = gap_after + target - gap_first;
    rd_map     = (pos_g < gap_first) ? pos_g : (pos_g + gap_after - gap_first);
    rd_start   = move_right ? gap_after : (gap_first - gbe_pkg::gap_t'(1));
    wr_start   = move_right ? gap_first : (gap_after - gbe_pkg::gap_t'(1));
  end

  // Store port muxing: shift traffic during a move, insert byte at the end
  always_comb begin
    ram_raddr = (state == S_MOVE) ? rd_ptr : rd_map[gbe_pkg::ADDR_W-1:0];
    ram_we    = pend || ((state == S_APPLY) && op_insert);
    ram_waddr = pend ? pend_addr : ins_addr;
    ram_wdata = pend ? ram_rdata : ins_byte;
  end

  gbe_ram #(
    .WIDTH (gbe_pkg::BYTE_W),
    .DEPTH (gbe_pkg::CAPACITY)
  ) u_text_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state and gap registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gap_first <= '0;
      gap_after <= gbe_pkg::CAP_G;
      done      <= 1'b0;
      pend      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (kind)
              gbe_pkg::KIND_INSERT: begin
                if (full) begin
                  done <= 1'b1;
                end else begin
                  gap_first <= target + gbe_pkg::gap_t'(1);
                  gap_after <= ga_moved;
                  state     <= S_MOVE;
                end
              end
              gbe_pkg::KIND_DELETE: begin
                if (pos_gt || (count == '0)) begin
                  done <= 1'b1;
                end else begin
                  gap_first <= target;
                  gap_after <= ga_moved + del_cnt;
                  state     <= S_MOVE;
                end
              end
              gbe_pkg::KIND_READ: begin
                if (pos_ge) begin
                  done <= 1'b1;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_MOVE: begin
          // One byte read per cycle; its write lands in the next cycle
          if (remain != '0) begin
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_APPLY;
            end
          end
        end
        S_APPLY: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: move pointers, insert payload, result fields
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        dir_right <= move_right;
        remain    <= move_dist;
        rd_ptr    <= rd_start[gbe_pkg::ADDR_W-1:0];
        wr_ptr    <= wr_start[gbe_pkg::ADDR_W-1:0];
        op_insert <= (kind == gbe_pkg::KIND_INSERT);
        ins_addr  <= target[gbe_pkg::ADDR_W-1:0];
        ins_byte  <= data_byte;
        read_byte <= '0;
        length    <= gbe_pkg::pos_t'(len);
        case (kind)
          gbe_pkg::KIND_INSERT: status <= full ? gbe_pkg::ST_FULL : gbe_pkg::ST_DONE;
          gbe_pkg::KIND_DELETE: status <= pos_gt ? gbe_pkg::ST_RANGE : gbe_pkg::ST_DONE;
          gbe_pkg::KIND_READ:   status <= pos_ge ? gbe_pkg::ST_RANGE : gbe_pkg::ST_DONE;
          default:              status <= gbe_pkg::ST_RANGE;
        endcase
      end
      S_READ: begin
        read_byte <= ram_rdata;
        length    <= gbe_pkg::pos_t'(len);
        status    <= gbe_pkg::ST_DONE;
      end
      S_MOVE: begin
        if (remain != '0) begin
          remain    <= remain - gbe_pkg::gap_t'(1);
          pend_addr <= wr_ptr;
          if (dir_right) begin
            rd_ptr <= rd_ptr + gbe_pkg::addr_t'(1);
            wr_ptr <= wr_ptr + gbe_pkg::addr_t'(1);
          end else begin
            rd_ptr <= rd_ptr - gbe_pkg::addr_t'(1);
            wr_ptr <= wr_ptr - gbe_pkg::addr_t'(1);
          end
        end
      end
      S_APPLY: begin
        read_byte <= '0;
        length    <= gbe_pkg::pos_t'(len);
        status    <= gbe_pkg::ST_DONE;
      end
      default: begin
        read_byte <= '0;
      end
    endcase
  end

endmodule
`default_nettype wire
